/* hw/rtl/spm_pkg.sv */
// ----------------------------------------------------------------------------
// spm_pkg - shared types for the sorted page-range merger
// Record and merged-range payload structs, result buffer defaults.
// ----------------------------------------------------------------------------
package spm_pkg;

    // Default depth of the result buffer (one item may push two results).
    localparam int OUT_DEPTH = 4;

    typedef struct packed {
        logic [31:0] file_key;
        logic [30:0] first_page;
        logic [19:0] page_count;
        logic        group_last;
    } t_rec;

    typedef struct packed {
        logic [31:0] range_key;
        logic [30:0] range_start;
        logic [31:0] range_pages;
        logic        group_end;
        logic        last_for_input;
    } t_range;

endpackage

/* hw/rtl/sorted_page_range_merger.sv */
// ----------------------------------------------------------------------------
// sorted_page_range_merger - merges sorted page-access records into ranges
// Holds one pending range per file group, extends it with overlapping or
// adjoining records and emits it when a record lies beyond it or the group
// ends.
// ----------------------------------------------------------------------------
//  channel   valid     ready     payload    direction
//  record    i_valid   o_ready   i_data     in
//  range     o_valid   i_ready   o_data     out
//
//  A record is taken into the input register and merged from there: one
//  record per cycle while the result buffer has room for two results.
//  Its ranges are registered in the result buffer. A record causes zero,
//  one or two ranges; the output drains one range per cycle while i_ready
//  is high, so the output sets the sustained rate when most records give two.
//  Reset clears the pending range, input register and result buffer.
//  Output stalls back up through the buffer into o_ready.
// ----------------------------------------------------------------------------
module sorted_page_range_merger #(
    parameter int P_OUT_DEPTH = spm_pkg::OUT_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  spm_pkg::t_rec   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output spm_pkg::t_range o_data
);
    import spm_pkg::*;

    localparam int AW = (P_OUT_DEPTH > 1) ? $clog2(P_OUT_DEPTH) : 1;
    localparam int CW = $clog2(P_OUT_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(P_OUT_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(P_OUT_DEPTH);

    // input register
    logic  r_in_valid;
    t_rec  r_in;

    // pending range
    logic        r_pend_valid;
    logic [31:0] r_pend_key;
    logic [30:0] r_pend_start;
    logic [31:0] r_pend_len;
    logic        n_pend_valid;
    logic [31:0] n_pend_key;
    logic [30:0] n_pend_start;
    logic [31:0] n_pend_len;

    // result buffer
    t_range        r_mem [P_OUT_DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic          pop;
    logic          do_proc;
    logic [CW-1:0] room;

    logic        key_chg;
    logic        eff_valid;
    logic [31:0] rec_end;
    logic [32:0] pend_end;
    logic        covered;
    logic        touch;
    logic        beyond;
    logic        emit_first;
    logic        emit_last;
    t_range      res_first;
    t_range      res_last;
    t_range      slot0;
    logic [AW-1:0] wr_ptr1;
    logic [1:0]    n_push;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_PTR) ? '0 : p + AW'(1);
    endfunction

    assign pop     = o_valid && i_ready;
    assign room    = DEPTH_C - r_count + CW'(pop);
    assign do_proc = r_in_valid && (room >= CW'(2));
    assign o_ready = !r_in_valid || do_proc;

    // merge decision
    always_comb begin
        key_chg   = r_pend_valid && (r_in.file_key != r_pend_key);
        eff_valid = r_pend_valid && !key_chg;
        rec_end   = {1'b0, r_in.first_page} + {12'b0, r_in.page_count};
        pend_end  = {2'b0, r_pend_start} + {1'b0, r_pend_len};
        covered   = eff_valid && (pend_end >= {1'b0, rec_end});
        touch     = eff_valid && !covered && (pend_end >= {2'b0, r_in.first_page});
        beyond    = eff_valid && !covered && !touch;

        n_pend_key   = r_pend_key;
        n_pend_start = r_pend_start;
        n_pend_len   = r_pend_len;
        if (!eff_valid) begin
            n_pend_key   = r_in.file_key;
            n_pend_start = r_in.first_page;
            n_pend_len   = {12'b0, r_in.page_count};
        end else if (touch) begin
            n_pend_len = rec_end - {1'b0, r_pend_start};
        end else if (beyond) begin
            n_pend_start = r_in.first_page;
            n_pend_len   = {12'b0, r_in.page_count};
        end
        n_pend_valid = !r_in.group_last;

        emit_first = key_chg || beyond;
        emit_last  = r_in.group_last;

        res_first.range_key      = r_pend_key;
        res_first.range_start    = r_pend_start;
        res_first.range_pages    = r_pend_len;
        res_first.group_end      = key_chg;
        res_first.last_for_input = !emit_last;

        res_last.range_key      = n_pend_key;
        res_last.range_start    = n_pend_start;
        res_last.range_pages    = n_pend_len;
        res_last.group_end      = 1'b1;
        res_last.last_for_input = 1'b1;

        slot0   = emit_first ? res_first : res_last;
        n_push  = {1'b0, emit_first} + {1'b0, emit_last};
        wr_ptr1 = ptr_inc(r_wr_ptr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_in <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (do_proc) begin
            r_pend_valid <= n_pend_valid;
        end
        if (do_proc) begin
            r_pend_key   <= n_pend_key;
            r_pend_start <= n_pend_start;
            r_pend_len   <= n_pend_len;
        end
    end

    // buffer storage
    always_ff @(posedge i_clk) begin
        if (do_proc && (n_push != 2'd0)) begin
            r_mem[r_wr_ptr] <= slot0;
        end
        if (do_proc && (n_push == 2'd2)) begin
            r_mem[wr_ptr1] <= res_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_proc) begin
                unique case (n_push)
                    2'd1:    r_wr_ptr <= wr_ptr1;
                    2'd2:    r_wr_ptr <= ptr_inc(wr_ptr1);
                    default: r_wr_ptr <= r_wr_ptr;
                endcase
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            r_count <= r_count + (do_proc ? CW'(n_push) : CW'(0)) - CW'(pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("result buffer count exceeds depth");

    a_group_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_proc && r_in.group_last |=> !r_pend_valid)
        else $error("pending range survives group end");

    a_pair_together: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop && !o_data.last_for_input |=> o_valid)
        else $error("second result of a record missing");

    a_hold_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !do_proc |=> r_in_valid && $stable(r_in))
        else $error("stalled record lost");

endmodule
